/* hw/rtl/min_max_normalizer_macros.svh */
// assertion helpers
`ifndef MIN_MAX_NORMALIZER_MACROS_SVH
`define MIN_MAX_NORMALIZER_MACROS_SVH
`define MMN_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define MMN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

/* hw/rtl/mmn_pkg.sv */
`default_nettype none
package mmn_pkg;
	localparam int MaxVectorsDefault = 256;
	localparam int MaxDimsDefault = 16;
	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_READ = 1'b1;
	localparam logic [1:0] REG_NORM_MODE = 2'd0;
	localparam logic [1:0] REG_DIMS_IN_USE = 2'd1;

	typedef struct packed {
		logic op;
		logic signed [31:0] value;
		logic [7:0] class_index;
		logic [7:0] vector_index;
		logic [3:0] element_index;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] normalized_value;
		logic [7:0] class_of_vector;
		logic [8:0] vector_count;
		logic range_error;
		logic index_error;
	} out_item_t;

	// job handed from front to divider
	typedef struct packed {
		logic do_div;
		logic [63:0] numer;
		logic [32:0] denom;
		logic [7:0] cls;
		logic [8:0] count;
		logic rerr;
		logic ierr;
	} job_t;
endpackage
`default_nettype wire

/* hw/rtl/mmn_front.sv */
`default_nettype none
module mmn_front #(
	parameter int MAX_VECTORS = mmn_pkg::MaxVectorsDefault,
	parameter int MAX_DIMS = mmn_pkg::MaxDimsDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic take,
	input wire mmn_pkg::in_item_t item,
	input wire logic norm_mode,
	input wire logic [4:0] dims_in_use,
	output logic job_valid,
	output mmn_pkg::job_t job
);
	import mmn_pkg::*;
	localparam int VW = $clog2(MAX_VECTORS + 1);
	localparam int VA = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
	localparam int DA = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int DW = $clog2(MAX_DIMS + 1);
	localparam int EA = (MAX_VECTORS * MAX_DIMS > 1) ? $clog2(MAX_VECTORS * MAX_DIMS) : 1;

	logic signed [31:0] elem_mem [MAX_VECTORS*MAX_DIMS];
	logic [7:0] cls_mem [MAX_VECTORS];
	logic signed [31:0] dmax_q [MAX_DIMS];
	logic signed [31:0] dmin_q [MAX_DIMS];
	logic signed [31:0] amax_q, amin_q;
	logic [VW-1:0] stored_q;
	logic [DW-1:0] fill_q;

	logic [DW-1:0] dims;
	logic [DA-1:0] pos;
	logic [DW-1:0] pos_next;
	logic full, bad;
	logic [VA-1:0] wv, rv;
	logic [DA-1:0] re;
	logic [EA-1:0] wa, ra;

	// read stage s1
	logic go_s1, bad_s1;
	logic signed [31:0] x_s1, mx_s1, mn_s1;
	logic [7:0] cls_s1;

	always_comb begin
		if (dims_in_use == 5'd0) dims = DW'(1);
		else if (32'(dims_in_use) > MAX_DIMS) dims = DW'(MAX_DIMS);
		else dims = DW'(dims_in_use);
		pos = (32'(fill_q) >= MAX_DIMS) ? DA'(MAX_DIMS - 1) : fill_q[DA-1:0];
		pos_next = DW'(pos) + DW'(1);
		full = 32'(stored_q) >= MAX_VECTORS;
		wv = stored_q[VA-1:0];
		rv = VA'(item.vector_index);
		re = DA'(item.element_index);
		wa = EA'(32'(wv) * MAX_DIMS + 32'(pos));
		ra = EA'(32'(rv) * MAX_DIMS + 32'(re));
		bad = (32'(item.vector_index) >= 32'(stored_q)) ||
			(32'(item.element_index) >= 32'(dims));
	end

	always_ff @(posedge clk) begin
		if (take && item.op == OP_APPEND && !full) begin
			elem_mem[wa] <= item.value;
			if (fill_q == '0) cls_mem[wv] <= item.class_index;
		end
		if (take && item.op == OP_READ) begin
			x_s1 <= elem_mem[ra];
			cls_s1 <= cls_mem[rv];
			mx_s1 <= norm_mode ? amax_q : dmax_q[re];
			mn_s1 <= norm_mode ? amin_q : dmin_q[re];
			bad_s1 <= bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_DIMS; i++) begin
				dmax_q[i] <= 32'sh8000_0000;
				dmin_q[i] <= 32'sh7fff_ffff;
			end
			amax_q <= '0;
			amin_q <= '0;
			stored_q <= '0;
			fill_q <= '0;
			go_s1 <= 1'b0;
			job_valid <= 1'b0;
			job <= '0;
		end else begin
			go_s1 <= take && item.op == OP_READ;
			job_valid <= 1'b0;
			if (take && item.op == OP_APPEND) begin
				job_valid <= 1'b1;
				job <= '0;
				job.ierr <= full;
				job.count <= 9'(stored_q);
				if (!full) begin
					if (item.value > dmax_q[pos]) dmax_q[pos] <= item.value;
					if (item.value < dmin_q[pos]) dmin_q[pos] <= item.value;
					if (item.value > amax_q) amax_q <= item.value;
					if (item.value < amin_q) amin_q <= item.value;
					if (pos_next >= dims) begin
						fill_q <= '0;
						stored_q <= stored_q + VW'(1);
						job.count <= 9'(stored_q + VW'(1));
					end else begin
						fill_q <= pos_next;
					end
				end
			end
			if (go_s1) begin
				job_valid <= 1'b1;
				job <= '0;
				job.count <= 9'(stored_q);
				if (bad_s1) job.ierr <= 1'b1;
				else if ($signed({mx_s1[31], mx_s1}) - $signed({mn_s1[31], mn_s1}) <= 0) begin
					job.rerr <= 1'b1;
					job.cls <= cls_s1;
				end else begin
					job.do_div <= 1'b1;
					job.cls <= cls_s1;
					job.numer <= 64'(33'($signed({x_s1[31], x_s1}) -
						$signed({mn_s1[31], mn_s1}))) << 15;
					job.denom <= 33'($signed({mx_s1[31], mx_s1}) -
						$signed({mn_s1[31], mn_s1}));
				end
			end
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/mmn_queue.sv */
`default_nettype none
module mmn_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire mmn_pkg::job_t din,
	input wire logic pop,
	output logic avail,
	output mmn_pkg::job_t dout,
	output logic [1:0] level
);
	import mmn_pkg::*;
	job_t buf_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign avail = cnt_q != 2'd0;
	assign dout = buf_q[rp_q];
	assign level = cnt_q;

	always_ff @(posedge clk) begin
		if (push) buf_q[wp_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/mmn_back.sv */
`default_nettype none
module mmn_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic avail,
	input wire mmn_pkg::job_t job,
	output logic pop,
	output logic idle,
	output logic result_valid,
	output mmn_pkg::out_item_t result
);
	import mmn_pkg::*;
	typedef enum logic {ST_IDLE, ST_DIV} state_t;
	state_t state_q;
	logic [63:0] num_q;
	logic [32:0] den_q;
	logic [33:0] rem_q;
	logic [5:0] cnt_q;
	logic [31:0] quo_q;
	logic [7:0] cls_q;
	logic [8:0] count_q;
	logic [33:0] trial;
	logic [33:0] shifted;
	logic signed [33:0] qv;

	assign pop = avail && state_q == ST_IDLE;
	assign idle = state_q == ST_IDLE;
	// numerator is below 2^48; quotient fits 32 bits
	assign shifted = {rem_q[32:0], num_q[63]};
	assign trial = shifted - {1'b0, den_q};
	assign qv = $signed({2'b00, quo_q}) - 34'sd16384;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			result_valid <= 1'b0;
			result <= '0;
			num_q <= '0;
			den_q <= '0;
			rem_q <= '0;
			cnt_q <= '0;
			quo_q <= '0;
			cls_q <= '0;
			count_q <= '0;
		end else begin
			result_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (job.do_div) begin
							state_q <= ST_DIV;
							num_q <= job.numer << 16;
							den_q <= job.denom;
							rem_q <= '0;
							quo_q <= '0;
							cnt_q <= 6'd48;
							cls_q <= job.cls;
							count_q <= job.count;
						end else begin
							result_valid <= 1'b1;
							result.normalized_value <= '0;
							result.class_of_vector <= job.ierr ? 8'd0 : job.cls;
							result.vector_count <= job.count;
							result.range_error <= job.rerr;
							result.index_error <= job.ierr;
						end
					end
				end
				ST_DIV: begin
					// 48 steps while the count runs down, then the result is registered
					if (cnt_q != 6'd0) begin
						num_q <= num_q << 1;
						if (!trial[33]) begin
							rem_q <= trial;
							quo_q <= {quo_q[30:0], 1'b1};
						end else begin
							rem_q <= shifted;
							quo_q <= {quo_q[30:0], 1'b0};
						end
						cnt_q <= cnt_q - 6'd1;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_DIV && cnt_q == 6'd0) begin
				result_valid <= 1'b1;
				result.normalized_value <= (qv > 34'sd16384) ? 16'sd16384 :
					((qv < -34'sd16384) ? -16'sd16384 : 16'(qv));
				result.class_of_vector <= cls_q;
				result.vector_count <= count_q;
				result.range_error <= 1'b0;
				result.index_error <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/min_max_normalizer.sv */
// channel   | signals                              | handshake
// command   | start, busy, cmd                     | start && !busy
// config    | cfg_valid, cfg_ready, cfg_index/data | cfg_valid && cfg_ready
// result    | done, result                         | done strobe, one cycle
// append: result follows the job register, the queue and the result register; read: two read stages,
// the queue, a divider load, 48 restoring steps of one quotient bit, then the result register
// busy holds until the cycle after done, so one command at a time
// reset clears bounds, counts and control; stores are undefined until written
// the receiver cannot stall: each result is a one-cycle done strobe
`default_nettype none
`include "min_max_normalizer_macros.svh"
module min_max_normalizer #(
	parameter int MAX_VECTORS = mmn_pkg::MaxVectorsDefault,
	parameter int MAX_DIMS = mmn_pkg::MaxDimsDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire mmn_pkg::in_item_t cmd,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [1:0] cfg_index,
	input wire logic [31:0] cfg_data,
	output logic done,
	output mmn_pkg::out_item_t result
);
	import mmn_pkg::*;
	logic norm_mode_q;
	logic [4:0] dims_q;
	logic pend_q;
	logic take, job_valid, avail, pop, idle;
	job_t job, qjob;
	logic [1:0] level;

	assign take = start && !busy;
	assign busy = pend_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_mode_q <= 1'b0;
			dims_q <= 5'd16;
			pend_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_index == REG_NORM_MODE) norm_mode_q <= cfg_data[0];
			if (cfg_valid && cfg_index == REG_DIMS_IN_USE) dims_q <= cfg_data[4:0];
			if (take) pend_q <= 1'b1;
			else if (done) pend_q <= 1'b0;
		end
	end

	mmn_front #(.MAX_VECTORS(MAX_VECTORS), .MAX_DIMS(MAX_DIMS)) u_front (
		.clk, .arst_n, .take, .item(cmd), .norm_mode(norm_mode_q),
		.dims_in_use(dims_q), .job_valid, .job
	);
	mmn_queue u_queue (
		.clk, .arst_n, .push(job_valid), .din(job), .pop, .avail, .dout(qjob), .level
	);
	mmn_back u_back (
		.clk, .arst_n, .avail, .job(qjob), .pop, .idle, .result_valid(done), .result
	);

	`MMN_ASSERT_IMPL(a_no_start_take_busy, clk, arst_n, done, busy)
	`MMN_ASSERT_IMPL(a_queue_bound, clk, arst_n, 1'b1, level != 2'd3)
	`MMN_ASSERT_NEXT(a_done_clears, clk, arst_n, done && !take, !busy)
	`MMN_ASSERT_IMPL(a_pop_idle, clk, arst_n, pop, idle && avail)
endmodule
`default_nettype wire

/* tb/sv/min_max_normalizer_tb.sv */
module min_max_normalizer_tb;
	import mmn_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 60;

	class normalizer_scoreboard;
		logic signed [31:0] elem_mem [4096];
		bit elem_written [4096];
		logic [7:0] class_mem [256];
		logic signed [31:0] dim_hi [16];
		logic signed [31:0] dim_lo [16];
		logic signed [31:0] all_hi;
		logic signed [31:0] all_lo;
		int stored;
		int fill;
		bit mode_global;
		logic [4:0] dims_reg;
		out_item_t expected_results [$];
		int mismatches;

		function new();
			for (int i = 0; i < 16; i++) begin
				dim_hi[i] = 32'sh8000_0000;
				dim_lo[i] = 32'sh7fff_ffff;
			end
			for (int i = 0; i < 4096; i++) begin
				elem_written[i] = 0;
			end
			all_hi = 0;
			all_lo = 0;
			stored = 0;
			fill = 0;
			mode_global = 0;
			dims_reg = 5'd16;
			mismatches = 0;
		endfunction

		function int dims_eff();
			if (dims_reg == 0) return 1;
			if (dims_reg > 16) return 16;
			return dims_reg;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] data);
			if (idx == REG_NORM_MODE) mode_global = data[0];
			else if (idx == REG_DIMS_IN_USE) dims_reg = data[4:0];
		endfunction

		function void note_command(in_item_t c);
			out_item_t r;
			int pos;
			int v;
			int e;
			longint x;
			longint mx;
			longint mn;
			longint span;
			longint q;
			longint num;
			r = '0;
			if (c.op == OP_APPEND) begin
				if (stored >= 256) begin
					r.index_error = 1'b1;
				end else begin
					pos = fill;
					if (fill == 0) class_mem[stored] = c.class_index;
					elem_mem[stored * 16 + pos] = c.value;
					elem_written[stored * 16 + pos] = 1;
					if (c.value > dim_hi[pos]) dim_hi[pos] = c.value;
					if (c.value < dim_lo[pos]) dim_lo[pos] = c.value;
					if (c.value > all_hi) all_hi = c.value;
					if (c.value < all_lo) all_lo = c.value;
					fill = pos + 1;
					if (fill >= dims_eff()) begin
						fill = 0;
						stored++;
					end
				end
			end else begin
				v = c.vector_index;
				e = c.element_index;
				if (v >= stored || e >= dims_eff()) begin
					r.index_error = 1'b1;
				end else begin
					x = elem_mem[v * 16 + e];
					mx = mode_global ? all_hi : dim_hi[e];
					mn = mode_global ? all_lo : dim_lo[e];
					r.class_of_vector = class_mem[v];
					span = mx - mn;
					if (span <= 0) begin
						r.range_error = 1'b1;
					end else begin
						num = (x - mn) * 32768;
						q = num / span;
						if (num % span != 0 && num < 0) q = q - 1;
						q = q - 16384;
						if (q < -16384) q = -16384;
						if (q > 16384) q = 16384;
						r.normalized_value = q[15:0];
					end
				end
			end
			r.vector_count = stored[8:0];
			expected_results = {expected_results, r};
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat: %p", got);
				return;
			end
			want = expected_results.pop_front();
			if (got.normalized_value !== want.normalized_value
					|| got.class_of_vector !== want.class_of_vector
					|| got.vector_count !== want.vector_count
					|| got.range_error !== want.range_error
					|| got.index_error !== want.index_error) begin
				mismatches++;
				if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	in_item_t cmd = '0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic done;
	out_item_t result;

	normalizer_scoreboard sb = new();
	int sender_idle_pct = 0;
	int cycles = 0;

	min_max_normalizer uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.result(result)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(result);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic hold_off(int n);
		start <= 0;
		repeat (n) @(posedge clk);
	endtask

	task automatic send_command(in_item_t c);
		if ($urandom_range(0, 99) < sender_idle_pct) hold_off($urandom_range(1, 4));
		start <= 1;
		cmd <= c;
		do @(posedge clk); while (busy);
		sb.note_command(c);
	endtask

	// wait until every result is back and the divider has settled
	task automatic drain();
		start <= 0;
		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic [1:0] idx, logic [31:0] data);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		sb.write_reg(idx, data);
		@(posedge clk);
	endtask

	function automatic in_item_t append_item(logic signed [31:0] val, logic [7:0] cls);
		in_item_t c;
		c = '0;
		c.op = OP_APPEND;
		c.value = val;
		c.class_index = cls;
		c.vector_index = 8'($urandom);
		c.element_index = 4'($urandom);
		return c;
	endfunction

	function automatic in_item_t read_item(logic [7:0] v, logic [3:0] e);
		in_item_t c;
		c = '0;
		c.op = OP_READ;
		c.value = $urandom;
		c.class_index = 8'($urandom);
		c.vector_index = v;
		c.element_index = e;
		return c;
	endfunction

	function automatic in_item_t random_item(int read_pct);
		in_item_t c;
		int d;
		d = sb.dims_eff();
		c.op = ($urandom_range(0, 99) < read_pct) ? OP_READ : OP_APPEND;
		case ($urandom_range(0, 3))
			0: c.value = $urandom;
			1: c.value = $signed($urandom_range(0, 4000)) - 2000;
			2: c.value = ($urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000)
					^ ($urandom_range(0, 1) ? 32'hffff_ffff : 32'h0);
			default: c.value = $signed($urandom) >>> $urandom_range(0, 31);
		endcase
		c.class_index = 8'($urandom);
		if (sb.stored > 0 && $urandom_range(0, 9) < 8)
			c.vector_index = 8'($urandom_range(0, sb.stored - 1));
		else
			c.vector_index = 8'($urandom);
		c.element_index = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, d - 1))
			: 4'($urandom);
		// element 0 of a complete vector is always written
		if (c.op == OP_READ && c.vector_index < sb.stored && c.element_index < d
				&& !sb.elem_written[c.vector_index * 16 + c.element_index])
			c.element_index = 4'd0;
		return c;
	endfunction

	task automatic random_run(int n, int read_pct);
		for (int i = 0; i < n; i++) send_command(random_item(read_pct));
	endtask

	initial begin
		int extra;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		write_register(REG_NORM_MODE, 32'd0);
		write_register(REG_DIMS_IN_USE, 32'd3);
		send_command(read_item(8'd0, 4'd0));
		send_command(append_item(32'sh8000_0000, 8'd255));
		send_command(append_item(32'sh7fff_ffff, 8'd7));
		send_command(append_item(32'sh0, 8'd1));
		// single element per dimension: zero range
		for (int e = 0; e < 3; e++) send_command(read_item(8'd0, e[3:0]));
		send_command(append_item(32'sh7fff_ffff, 8'd0));
		send_command(append_item(32'sh8000_0000, 8'd255));
		send_command(append_item(-32'sd1, 8'd0));
		for (int e = 0; e < 3; e++) begin
			send_command(read_item(8'd0, e[3:0]));
			send_command(read_item(8'd1, e[3:0]));
		end
		send_command(read_item(8'd2, 4'd0));
		send_command(read_item(8'd0, 4'd3));
		send_command(read_item(8'd255, 4'd15));
		// partial vector cannot be read yet
		send_command(append_item(32'sh0001_0000, 8'haa));
		send_command(read_item(8'd2, 4'd0));
		drain();

		write_register(REG_NORM_MODE, 32'd1);
		write_register(REG_DIMS_IN_USE, 32'd5);
		sender_idle_pct = 33;
		random_run(50, 45);
		drain();
		random_run(50, 45);
		drain();

		write_register(REG_NORM_MODE, 32'hfffffffe);
		write_register(REG_DIMS_IN_USE, 32'hffffffff);
		sender_idle_pct = 81;
		random_run(40, 45);
		drain();
		// dimension count changed with a vector possibly half filled
		write_register(REG_NORM_MODE, 32'd1);
		write_register(REG_DIMS_IN_USE, 32'd1);
		random_run(60, 45);
		drain();

		write_register(REG_NORM_MODE, 32'd0);
		write_register(REG_DIMS_IN_USE, 32'hffffffe0);
		sender_idle_pct = 0;
		extra = 0;
		while (sb.stored < 256 || extra < 40) begin
			send_command(random_item(sb.stored < 256 ? 10 : 50));
			if (sb.stored >= 256) extra++;
		end

		start <= 0;
		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/mmn_pkg.sv
hw/rtl/mmn_front.sv
hw/rtl/mmn_queue.sv
hw/rtl/mmn_back.sv
hw/rtl/min_max_normalizer.sv
tb/sv/min_max_normalizer_tb.sv
